// File: rtl/core/hsl_to_rgb_converter_top_assert.svh
// Assertion macros for the HSL to RGB converter.
`ifndef HSL_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define HTR_ASSERT_IMP(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("htr: same-cycle check failed");
`define HTR_ASSERT_NXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("htr: next-cycle check failed");
`else
`define HTR_ASSERT_IMP(lbl, clk, rst_n, cond, prop)
`define HTR_ASSERT_NXT(lbl, clk, rst_n, cond, prop)
`endif
`endif

// File: rtl/core/htr_pkg.sv
package htr_pkg;

    localparam int unsigned IN_W  = 16;
    localparam int unsigned OUT_W = 8;

    localparam logic [16:0] FULL_IN  = 17'd65535;
    localparam logic [16:0] TWO_FULL = 17'd131070;

    typedef logic [2:0] t_sector;

    localparam t_sector SEC_R_TO_Y = 3'd0;
    localparam t_sector SEC_Y_TO_G = 3'd1;
    localparam t_sector SEC_G_TO_C = 3'd2;
    localparam t_sector SEC_C_TO_B = 3'd3;
    localparam t_sector SEC_B_TO_M = 3'd4;
    localparam t_sector SEC_M_TO_R = 3'd5;

    typedef struct packed {
        t_sector     sector;
        logic [16:0] bfrac;
    } t_hue_side;

    typedef struct packed {
        logic first;
        logic second;
    } t_pair_en;

endpackage

// File: rtl/core/htr_if.sv
interface htr_in_if;
    logic                     valid;
    logic                     ready;
    logic [htr_pkg::IN_W-1:0] hue;
    logic [htr_pkg::IN_W-1:0] saturation;
    logic [htr_pkg::IN_W-1:0] lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

interface htr_out_if;
    logic                      valid;
    logic                      ready;
    logic [htr_pkg::OUT_W-1:0] red;
    logic [htr_pkg::OUT_W-1:0] green;
    logic [htr_pkg::OUT_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: rtl/core/htr_pre.sv
module htr_pre (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [htr_pkg::IN_W-1:0] i_hue,
    input  logic [htr_pkg::IN_W-1:0] i_sat,
    input  logic [htr_pkg::IN_W-1:0] i_light,
    output logic [31:0]              o_prod,
    output logic [htr_pkg::IN_W-1:0] o_light,
    output htr_pkg::t_hue_side       o_side
);
    import htr_pkg::*;

    logic [16:0] twol;
    logic [15:0] amp;
    logic [18:0] h6;
    logic [16:0] tpos;
    t_hue_side   side;

    logic [31:0] r_prod;
    logic [15:0] r_light;
    t_hue_side   r_side;

    always_comb begin
        twol = {i_light, 1'b0};
        if (twol >= FULL_IN) begin
            amp = 16'(TWO_FULL - twol);
        end else begin
            amp = twol[15:0];
        end
        h6   = {1'b0, i_hue, 2'b00} + {2'b00, i_hue, 1'b0};
        tpos = h6[16:0];
        side.sector = h6[18:16];
        if (tpos[16]) begin
            side.bfrac = 17'(18'h20000 - {1'b0, tpos});
        end else begin
            side.bfrac = tpos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= 32'(amp) * 32'(i_sat);
            r_light <= i_light;
            r_side  <= side;
        end
    end

    assign o_prod  = r_prod;
    assign o_light = r_light;
    assign o_side  = r_side;
endmodule

// File: rtl/core/htr_div.sv
module htr_div #(
    parameter int unsigned NUM_W = 40
) (
    input  logic              i_clk,
    input  htr_pkg::t_pair_en i_en,
    input  logic [NUM_W-1:0]  i_num,
    output logic [NUM_W-16:0] o_quo
);
    import htr_pkg::*;

    localparam int unsigned TERMS = (NUM_W + 15) / 16;
    localparam int unsigned QUO_W = NUM_W - 15;
    localparam int unsigned EXT_W = (QUO_W > 17) ? QUO_W : 17;

    // Quotient by 65535 as a sum of shifted copies; it lands on q or q-1.
    logic [NUM_W:0]   sum;
    logic [EXT_W-1:0] est_ext;
    logic [16:0]      rem;
    logic [QUO_W-1:0] n_quo;

    logic [QUO_W-1:0] r_est;
    logic [16:0]      r_lo;
    logic [QUO_W-1:0] r_quo;

    always_comb begin
        sum = '0;
        for (int k = 0; k < TERMS; k++) begin
            sum = sum + (NUM_W + 1)'(i_num >> (16 * k));
        end
    end

    always_comb begin
        est_ext = EXT_W'(r_est);
        rem     = r_lo + est_ext[16:0] - {est_ext[0], 16'h0000};
        n_quo   = r_est + QUO_W'(rem >= FULL_IN);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.first) begin
            r_est <= sum[NUM_W:16];
            r_lo  <= i_num[16:0];
        end
        if (i_en.second) begin
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;
endmodule

// File: rtl/core/htr_post.sv
module htr_post #(
    parameter int unsigned FRAC_W = 16
) (
    input  logic                      i_clk,
    input  htr_pkg::t_pair_en         i_en,
    input  logic [FRAC_W:0]           i_chroma,
    input  logic [FRAC_W:0]           i_light,
    input  htr_pkg::t_hue_side        i_side,
    output logic [htr_pkg::OUT_W-1:0] o_red,
    output logic [htr_pkg::OUT_W-1:0] o_green,
    output logic [htr_pkg::OUT_W-1:0] o_blue
);
    import htr_pkg::*;

    function automatic logic [7:0] chan(input logic [FRAC_W:0] comp,
                                        input logic signed [FRAC_W+1:0] ofs);
        logic signed [FRAC_W+2:0] total;
        logic [FRAC_W+9:0]        scaled;
        logic [9:0]               val;
        total  = $signed({2'b00, comp}) + $signed({ofs[FRAC_W+1], ofs});
        scaled = {total[FRAC_W+1:0], 8'h00} - (FRAC_W + 10)'(total[FRAC_W+1:0]);
        val    = scaled[FRAC_W+9:FRAC_W];
        if (total[FRAC_W+2] || (total == '0)) begin
            chan = 8'h00;
        end else if (val > 10'd255) begin
            chan = 8'hFF;
        end else begin
            chan = val[7:0];
        end
    endfunction

    logic [FRAC_W+17:0]      prod_x;
    logic signed [FRAC_W+1:0] ofs;
    logic [FRAC_W:0]         comp_r;
    logic [FRAC_W:0]         comp_g;
    logic [FRAC_W:0]         comp_b;

    logic [FRAC_W:0]          r_x;
    logic [FRAC_W:0]          r_c;
    logic signed [FRAC_W+1:0] r_m;
    t_sector                  r_sec;
    logic [OUT_W-1:0]         r_red;
    logic [OUT_W-1:0]         r_green;
    logic [OUT_W-1:0]         r_blue;

    always_comb begin
        prod_x = (FRAC_W + 18)'(i_chroma) * (FRAC_W + 18)'(i_side.bfrac);
        ofs    = $signed({1'b0, i_light}) - $signed({2'b00, i_chroma[FRAC_W:1]});
    end

    always_comb begin
        comp_r = '0;
        comp_g = '0;
        comp_b = '0;
        case (r_sec)
            SEC_R_TO_Y: begin
                comp_r = r_c;
                comp_g = r_x;
            end
            SEC_Y_TO_G: begin
                comp_r = r_x;
                comp_g = r_c;
            end
            SEC_G_TO_C: begin
                comp_g = r_c;
                comp_b = r_x;
            end
            SEC_C_TO_B: begin
                comp_g = r_x;
                comp_b = r_c;
            end
            SEC_B_TO_M: begin
                comp_r = r_x;
                comp_b = r_c;
            end
            default: begin
                comp_r = r_c;
                comp_b = r_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.first) begin
            r_x   <= prod_x[FRAC_W+16:16];
            r_c   <= i_chroma;
            r_m   <= ofs;
            r_sec <= i_side.sector;
        end
        if (i_en.second) begin
            r_red   <= chan(comp_r, r_m);
            r_green <= chan(comp_g, r_m);
            r_blue  <= chan(comp_b, r_m);
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
endmodule

// File: rtl/core/hsl_to_rgb_converter_top.sv
// An accepted input item passes the pre stage, the divider estimate and correction stages and the post stages.
// Throughput: one item per clock while the sink is ready; each stage moves up when its successor frees.
// The depth is set by the two chained divide-by-65535 units behind the chroma
// multiplier, each an estimate stage and a correction stage.
// Reset is synchronous and active low; it clears the stage valid bits only.
`include "hsl_to_rgb_converter_top_assert.svh"

module hsl_to_rgb_converter_top #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    htr_in_if.sink     i_pix,
    htr_out_if.source  o_pix
);
    import htr_pkg::*;

    localparam int unsigned STAGES = 7;
    localparam int unsigned DIV1_W = 32 + FRACTION_BITS;
    localparam int unsigned DIV2_W = DIV1_W - 15;
    localparam int unsigned LF_W   = 16 + FRACTION_BITS;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] stage_en;

    logic [31:0]           prod;
    logic [IN_W-1:0]       light_s1;
    t_hue_side             side_s1;
    logic [IN_W-1:0]       r_light [0:1];
    t_hue_side             r_side [0:3];
    logic [DIV2_W-1:0]     quo1;
    logic [DIV2_W-16:0]    quo2;
    logic [LF_W-16:0]      light_frac;

    t_pair_en en_div1;
    t_pair_en en_div2;
    t_pair_en en_post;

    always_comb begin
        stage_en[STAGES-1] = !r_vld[STAGES-1] || o_pix.ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !r_vld[i] || stage_en[i+1];
        end
        n_vld = r_vld;
        if (stage_en[0]) begin
            n_vld[0] = i_pix.valid;
        end
        for (int i = 1; i < STAGES; i++) begin
            if (stage_en[i]) begin
                n_vld[i] = r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_pix.ready = stage_en[0];
    assign o_pix.valid = r_vld[STAGES-1];

    assign en_div1 = '{first: stage_en[1], second: stage_en[2]};
    assign en_div2 = '{first: stage_en[3], second: stage_en[4]};
    assign en_post = '{first: stage_en[5], second: stage_en[6]};

    htr_pre u_pre (
        .i_clk   (i_clk),
        .i_en    (stage_en[0]),
        .i_hue   (i_pix.hue),
        .i_sat   (i_pix.saturation),
        .i_light (i_pix.lightness),
        .o_prod  (prod),
        .o_light (light_s1),
        .o_side  (side_s1)
    );

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_light[0] <= light_s1;
            r_side[0]  <= side_s1;
        end
        if (stage_en[2]) begin
            r_light[1] <= r_light[0];
        end
        for (int i = 1; i < 4; i++) begin
            if (stage_en[i+1]) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    htr_div #(.NUM_W(DIV1_W)) u_div_scale (
        .i_clk (i_clk),
        .i_en  (en_div1),
        .i_num ({prod, {FRACTION_BITS{1'b0}}}),
        .o_quo (quo1)
    );

    htr_div #(.NUM_W(DIV2_W)) u_div_chroma (
        .i_clk (i_clk),
        .i_en  (en_div2),
        .i_num (quo1),
        .o_quo (quo2)
    );

    htr_div #(.NUM_W(LF_W)) u_div_light (
        .i_clk (i_clk),
        .i_en  (en_div2),
        .i_num ({r_light[1], {FRACTION_BITS{1'b0}}}),
        .o_quo (light_frac)
    );

    htr_post #(.FRAC_W(FRACTION_BITS)) u_post (
        .i_clk    (i_clk),
        .i_en     (en_post),
        .i_chroma (quo2[FRACTION_BITS:0]),
        .i_light  (light_frac),
        .i_side   (r_side[3]),
        .o_red    (o_pix.red),
        .o_green  (o_pix.green),
        .o_blue   (o_pix.blue)
    );

    `HTR_ASSERT_IMP(a_in_block_needs_full_head, i_clk, i_rst_n, !i_pix.ready, r_vld[0])
    `HTR_ASSERT_IMP(a_sink_ready_opens_input, i_clk, i_rst_n, o_pix.ready, i_pix.ready)
    `HTR_ASSERT_NXT(a_mid_stage_holds, i_clk, i_rst_n, r_vld[3] && !stage_en[3], r_vld[3])
endmodule

// File: sim/tb.sv
module tb;
    import htr_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int RAND_ITEMS  = 650;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct {
        logic [15:0] hue;
        logic [15:0] sat;
        logic [15:0] lit;
        bit          fixed_exp;
        t_rgb        rgb;
    } t_stim_row;

    localparam int N_ROWS = 21;

    // Black and white rows carry their result; the rest go through the predictor.
    t_stim_row directed_rows [N_ROWS] = '{
        '{16'h0000, 16'h0000, 16'h0000, 1'b1, '{8'd0,   8'd0,   8'd0  }},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{16'h0000, 16'hFFFF, 16'h0000, 1'b1, '{8'd0,   8'd0,   8'd0  }},
        '{16'h8000, 16'h0000, 16'hFFFF, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{16'd0,     16'hFFFF, 16'h7FFF, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{16'd10922, 16'hFFFF, 16'h7FFF, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{16'd10923, 16'hFFFF, 16'h7FFF, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{16'd21845, 16'hFFFF, 16'h7FFF, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{16'd21846, 16'hFFFF, 16'h7FFF, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{16'd32767, 16'hFFFF, 16'h7FFF, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{16'd32768, 16'hFFFF, 16'h7FFF, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{16'd43690, 16'hFFFF, 16'h7FFF, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{16'd43691, 16'hFFFF, 16'h7FFF, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{16'd54613, 16'hFFFF, 16'h7FFF, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{16'd54614, 16'hFFFF, 16'h7FFF, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{16'd65535, 16'hFFFF, 16'h7FFF, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{16'h0000, 16'h0000, 16'h8000, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{16'h5555, 16'hAAAA, 16'h5555, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{16'h1234, 16'hFFFF, 16'h0001, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{16'h9000, 16'hFFFF, 16'hFFFE, 1'b0, '{8'd0, 8'd0, 8'd0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    htr_in_if  in_ch ();
    htr_out_if out_ch ();

    hsl_to_rgb_converter_top #(
        .FRACTION_BITS(FRAC_BITS)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_pix  (in_ch),
        .o_pix  (out_ch)
    );

    t_rgb pending_rgb_q [$];
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   pixels_sent;
    int   pixels_checked;
    int   mismatch_count;
    int   cycle_count;
    t_rgb want_px;
    t_rgb got_px;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] channel8(input longint comp, input longint offset);
        longint          sum;
        longint unsigned scaled;
        sum = comp + offset;
        if (sum <= 0) begin
            return 8'd0;
        end
        scaled = ($unsigned(sum) * 64'd255) >> FRAC_BITS;
        return (scaled > 64'd255) ? 8'd255 : 8'(scaled);
    endfunction

    function automatic t_rgb convert_hsl(input logic [15:0] hue, input logic [15:0] sat,
                                         input logic [15:0] lit);
        longint unsigned twol, dev, span, chroma, lit_fx, h6, t, td, ramp, second;
        longint          offset, comp_r, comp_g, comp_b;
        t_sector         sector;
        t_rgb            px;
        twol   = 64'd2 * lit;
        dev    = (twol >= 64'd65535) ? twol - 64'd65535 : 64'd65535 - twol;
        span   = 64'd65535 - dev;
        chroma = ((span * sat) << FRAC_BITS) / 64'd4294836225;
        lit_fx = (64'(lit) << FRAC_BITS) / 64'd65535;
        h6     = 64'd6 * hue;
        sector = t_sector'(h6 >> 16);
        t      = h6 % 64'd131072;
        td     = (t >= 64'd65536) ? t - 64'd65536 : 64'd65536 - t;
        ramp   = 64'd65536 - td;
        second = (chroma * ramp) >> 16;
        offset = longint'(lit_fx) - longint'(chroma >> 1);
        comp_r = 0;
        comp_g = 0;
        comp_b = 0;
        case (sector)
            SEC_R_TO_Y: begin
                comp_r = chroma;
                comp_g = second;
            end
            SEC_Y_TO_G: begin
                comp_r = second;
                comp_g = chroma;
            end
            SEC_G_TO_C: begin
                comp_g = chroma;
                comp_b = second;
            end
            SEC_C_TO_B: begin
                comp_g = second;
                comp_b = chroma;
            end
            SEC_B_TO_M: begin
                comp_r = second;
                comp_b = chroma;
            end
            default: begin
                comp_r = chroma;
                comp_b = second;
            end
        endcase
        px.red   = channel8(comp_r, offset);
        px.green = channel8(comp_g, offset);
        px.blue  = channel8(comp_b, offset);
        return px;
    endfunction

    function automatic logic [15:0] pick_level();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'h7FFF;
            3: return 16'h8000;
            4: return 16'hFFFE;
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic send_pixel(input logic [15:0] hue, input logic [15:0] sat,
                              input logic [15:0] lit, input t_rgb want);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.hue        <= hue;
        in_ch.saturation <= sat;
        in_ch.lightness  <= lit;
        @(posedge clk);
        while (!in_ch.ready) begin
            @(posedge clk);
        end
        pending_rgb_q.push_back(want);
        pixels_sent++;
    endtask

    task automatic drain_pipeline();
        in_ch.valid <= 1'b0;
        while (pending_rgb_q.size() != 0) begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk) begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got_px = '{out_ch.red, out_ch.green, out_ch.blue};
            if (pending_rgb_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("Unexpected item: rgb %0d %0d %0d with nothing pending",
                             got_px.red, got_px.green, got_px.blue);
                end
            end else begin
                want_px = pending_rgb_q.pop_front();
                pixels_checked++;
                if (got_px.red !== want_px.red || got_px.green !== want_px.green ||
                    got_px.blue !== want_px.blue) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("Mismatch on item %0d: expected rgb %0d %0d %0d, got %0d %0d %0d",
                                 pixels_checked, want_px.red, want_px.green, want_px.blue,
                                 got_px.red, got_px.green, got_px.blue);
                    end
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d items pending.",
                 cycle_count, pending_rgb_q.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [15:0] hue, sat, lit;
        int          phase, k;
        in_ch.valid      <= 1'b0;
        in_ch.hue        <= '0;
        in_ch.saturation <= '0;
        in_ch.lightness  <= '0;
        rst_n            <= 1'b0;
        pixels_sent    = 0;
        pixels_checked = 0;
        mismatch_count = 0;
        tx_idle_pct    = 38;
        rx_idle_pct    = 52;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            send_pixel(directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].lit,
                       directed_rows[i].fixed_exp ? directed_rows[i].rgb :
                       convert_hsl(directed_rows[i].hue, directed_rows[i].sat,
                                   directed_rows[i].lit));
        end
        drain_pipeline();

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 38;
                    rx_idle_pct = 52;
                end
                1: begin
                    tx_idle_pct = 52;
                    rx_idle_pct = 38;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            repeat (RAND_ITEMS) begin
                hue = 16'($urandom);
                sat = 16'($urandom);
                lit = 16'($urandom);
                case ($urandom_range(9))
                    0: begin
                        hue = pick_level();
                        sat = pick_level();
                        lit = pick_level();
                    end
                    1: begin
                        k   = $urandom_range(5);
                        hue = 16'((k * 65536 + 5) / 6 + $urandom_range(8) - 4);
                    end
                    2: begin
                        sat = pick_level();
                    end
                    default: begin
                    end
                endcase
                send_pixel(hue, sat, lit, convert_hsl(hue, sat, lit));
            end
            drain_pipeline();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Converted %0d pixels (%0d from the directed table) under three idling mixes;",
                 pixels_sent, N_ROWS);
        $display("%0d results compared, %0d mismatches, %0d still pending.",
                 pixels_checked, mismatch_count, pending_rgb_q.size());
        if (mismatch_count == 0 && pending_rgb_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
